### hw/rtl/assert_macros.svh
// Assertion macros shared by the frame buffer RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)
`endif
`endif

### hw/rtl/lrpf_pkg.sv
// Shared constants, codes and control types of the page frame buffer.
// No dependencies; used by lrpf_ctrl, lrpf_dp and the top level.
package lrpf_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 128;
  localparam int PAGE_ROWS     = 8;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES   = PAGE_COUNT * SCREEN_WIDTH;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int PAGE_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int COL_W         = $clog2(SCREEN_WIDTH);
  localparam int COORD_W       = 8;
  localparam int ERR_W         = COORD_W + 2;
  localparam int BYTE_W        = 8;
  localparam int DIRTY_W       = 7;
  localparam int ROW_BIT_W     = $clog2(PAGE_ROWS);

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_BYTE,
    ST_CLEAR
  } state_t;

  typedef enum logic [1:0] {
    RES_OK,
    RES_BAD,
    RES_BYTE,
    RES_PAGE
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     step;
    logic     rd_px;
    logic     rd_byte;
    logic     wr_px;
    logic     sweep_wr;
    logic     tab_fill;
    logic     tab_flush;
    logic     res_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic bad;
    logic line_done;
    logic sweep_last;
  } stat_t;

endpackage

### hw/rtl/line_raster_page_framebuffer_core.sv
// Top level of the page frame buffer with line drawer.
// Depends on lrpf_pkg, lrpf_ctrl, lrpf_dp and assert_macros.svh.
//
// Usage:
//   A command beat is taken at a rising edge with start high and busy low;
//   in_op selects draw line, read byte, flush page or clear display.
//   Each command yields one result beat: out_valid is high for exactly one
//   cycle with out_status, out_read_byte, out_page_written, out_dirty_min
//   and out_dirty_max. The receiver cannot stall; the result is gone after
//   that cycle. One command is worked at a time and busy stays high until
//   its result is out.
//   Steps from the accepting edge to the result cycle:
//     rejected command or flush: decode only; byte read: decode, then byte;
//     line: one read and one write of the frame memory port pair per pixel;
//     clear: one memory byte written per cycle, over all 2048 bytes.
//   Reset: rst_n is synchronous, active low. The dirty tables reset at once;
//   afterwards a sweep zeroes all 2048 bytes of frame memory with busy
//   high, and no result is given for it.
`include "assert_macros.svh"
module line_raster_page_framebuffer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_op,
  input  logic [lrpf_pkg::COORD_W-1:0]   in_x_start,
  input  logic [lrpf_pkg::COORD_W-1:0]   in_y_start,
  input  logic [lrpf_pkg::COORD_W-1:0]   in_x_end,
  input  logic [lrpf_pkg::COORD_W-1:0]   in_y_end,
  input  logic                           in_color,
  input  logic [lrpf_pkg::COORD_W-1:0]   in_page_index,
  input  logic [lrpf_pkg::COORD_W-1:0]   in_column_index,
  output logic                           out_valid,
  output logic                           out_status,
  output logic [lrpf_pkg::BYTE_W-1:0]    out_read_byte,
  output logic                           out_page_written,
  output logic [lrpf_pkg::DIRTY_W-1:0]   out_dirty_min,
  output logic [lrpf_pkg::DIRTY_W-1:0]   out_dirty_max
);
  import lrpf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lrpf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lrpf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_op),
    .in_x_start       (in_x_start),
    .in_y_start       (in_y_start),
    .in_x_end         (in_x_end),
    .in_y_end         (in_y_end),
    .in_color         (in_color),
    .in_page_index    (in_page_index),
    .in_column_index  (in_column_index),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_read_byte    (out_read_byte),
    .out_page_written (out_page_written),
    .out_dirty_min    (out_dirty_min),
    .out_dirty_max    (out_dirty_max)
  );

  `ASSERT_CLK(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accepted beat did not raise busy")
  `ASSERT_CLK(a_result_idle, clk, rst_n, out_valid |-> !busy, "result beat while still busy")
  `ASSERT_CLK(a_result_after_work, clk, rst_n, out_valid |-> $past(busy), "result beat without work")

endmodule

### hw/rtl/lrpf_ctrl.sv
// Sequencer of the page frame buffer: decodes commands and steps the datapath.
// Depends on lrpf_pkg.
module lrpf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  lrpf_pkg::stat_t stat,
  output lrpf_pkg::cmd_t  cmd,
  output logic            busy
);
  import lrpf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.res_sel = RES_OK;
    busy        = 1'b1;
    unique case (state_r)
      ST_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.bad) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_BAD;
          state_nxt    = ST_IDLE;
        end else begin
          unique case (stat.op)
            OP_DRAW: state_nxt = ST_PIX_RD;
            OP_READ: begin
              cmd.rd_byte = 1'b1;
              state_nxt   = ST_BYTE;
            end
            OP_FLUSH: begin
              cmd.tab_flush = 1'b1;
              cmd.res_load  = 1'b1;
              cmd.res_sel   = RES_PAGE;
              state_nxt     = ST_IDLE;
            end
            OP_CLEAR: begin
              cmd.tab_fill = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PIX_RD: begin
        cmd.rd_px = 1'b1;
        state_nxt = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        cmd.wr_px = 1'b1;
        if (stat.line_done) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_PIX_RD;
        end
      end
      ST_BYTE: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_BYTE;
        state_nxt    = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

endmodule

### hw/rtl/lrpf_dp.sv
// Datapath of the page frame buffer: frame memory, page dirty tables,
// line stepper and result registers. Depends on lrpf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lrpf_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lrpf_pkg::cmd_t                 cmd,
  output lrpf_pkg::stat_t                stat,
  input  logic [1:0]                     in_op,
  input  logic [lrpf_pkg::COORD_W-1:0]   in_x_start,
  input  logic [lrpf_pkg::COORD_W-1:0]   in_y_start,
  input  logic [lrpf_pkg::COORD_W-1:0]   in_x_end,
  input  logic [lrpf_pkg::COORD_W-1:0]   in_y_end,
  input  logic                           in_color,
  input  logic [lrpf_pkg::COORD_W-1:0]   in_page_index,
  input  logic [lrpf_pkg::COORD_W-1:0]   in_column_index,
  output logic                           out_valid,
  output logic                           out_status,
  output logic [lrpf_pkg::BYTE_W-1:0]    out_read_byte,
  output logic                           out_page_written,
  output logic [lrpf_pkg::DIRTY_W-1:0]   out_dirty_min,
  output logic [lrpf_pkg::DIRTY_W-1:0]   out_dirty_max
);
  import lrpf_pkg::*;

  function automatic logic over(input logic [COORD_W-1:0] v, input int unsigned lim);
    over = ({1'b0, v} >= (COORD_W + 1)'(lim));
  endfunction

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [PAGE_W-1:0] pg,
                                                  input logic [COL_W-1:0] col);
    byte_addr = ADDR_W'(pg * SCREEN_WIDTH) + ADDR_W'(col);
  endfunction

  // latched command fields and line walk state
  op_t                      op_r;
  logic [COORD_W-1:0]       xs_r, ys_r, xe_r, ye_r, page_r, col_r;
  logic [COORD_W-1:0]       x_r, y_r, x_nxt, y_nxt;
  logic                     color_r, sx_r, sy_r;
  logic signed [ERR_W-1:0]  dx_r, dy_r, err_r, err_nxt;
  logic [COORD_W-1:0]       adx, ady;
  logic signed [ERR_W:0]    e2, dx_ext, dy_ext;

  assign adx = (in_x_end > in_x_start) ? in_x_end - in_x_start : in_x_start - in_x_end;
  assign ady = (in_y_end > in_y_start) ? in_y_end - in_y_start : in_y_start - in_y_end;

  assign e2     = {err_r, 1'b0};
  assign dx_ext = {dx_r[ERR_W-1], dx_r};
  assign dy_ext = {dy_r[ERR_W-1], dy_r};

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    err_nxt = err_r;
    if (e2 >= dy_ext) begin
      err_nxt = err_nxt + dy_r;
      x_nxt   = sx_r ? x_r + 1'b1 : x_r - 1'b1;
    end
    if (e2 <= dx_ext) begin
      err_nxt = err_nxt + dx_r;
      y_nxt   = sy_r ? y_r + 1'b1 : y_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_op);
      xs_r    <= in_x_start;
      ys_r    <= in_y_start;
      xe_r    <= in_x_end;
      ye_r    <= in_y_end;
      color_r <= in_color;
      page_r  <= in_page_index;
      col_r   <= in_column_index;
      x_r     <= in_x_start;
      y_r     <= in_y_start;
      dx_r    <= $signed({2'b00, adx});
      dy_r    <= -$signed({2'b00, ady});
      err_r   <= $signed({2'b00, adx}) - $signed({2'b00, ady});
      sx_r    <= in_x_start < in_x_end;
      sy_r    <= in_y_start < in_y_end;
    end else if (cmd.step) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
    end
  end

  // parameter check on the latched command
  logic bad;
  always_comb begin
    case (op_r)
      OP_DRAW:  bad = over(xs_r, SCREEN_WIDTH) || over(xe_r, SCREEN_WIDTH) ||
                      over(ys_r, SCREEN_HEIGHT) || over(ye_r, SCREEN_HEIGHT);
      OP_READ:  bad = over(page_r, PAGE_COUNT) || over(col_r, SCREEN_WIDTH);
      OP_FLUSH: bad = over(page_r, PAGE_COUNT);
      default:  bad = 1'b0;
    endcase
  end

  // clear sweep counter
  logic [ADDR_W-1:0] sweep_cnt_r;
  logic              sweep_last;
  assign sweep_last = (sweep_cnt_r == ADDR_W'(STORE_BYTES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_cnt_r <= sweep_last ? '0 : sweep_cnt_r + 1'b1;
    end
  end

  assign stat.op         = op_r;
  assign stat.bad        = bad;
  assign stat.line_done  = (x_r == xe_r) && (y_r == ye_r);
  assign stat.sweep_last = sweep_last;

  // frame memory
  logic [BYTE_W-1:0] mem [STORE_BYTES];
  logic [BYTE_W-1:0] rd_data_r, wr_data, bit_mask;
  logic [ADDR_W-1:0] px_addr, rd_addr, wr_addr;
  logic [PAGE_W-1:0] px_page, tab_page;
  logic [COL_W-1:0]  px_col;
  logic              mem_we, mem_re;

  assign px_page  = PAGE_W'(y_r >> ROW_BIT_W);
  assign px_col   = x_r[COL_W-1:0];
  assign px_addr  = byte_addr(px_page, px_col);
  assign rd_addr  = cmd.rd_byte ? byte_addr(page_r[PAGE_W-1:0], col_r[COL_W-1:0]) : px_addr;
  assign wr_addr  = cmd.sweep_wr ? sweep_cnt_r : px_addr;
  assign bit_mask = BYTE_W'(1) << y_r[ROW_BIT_W-1:0];
  assign wr_data  = cmd.sweep_wr ? '0 :
                    (color_r ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask));
  assign mem_we   = cmd.sweep_wr || cmd.wr_px;
  assign mem_re   = cmd.rd_px || cmd.rd_byte;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rd_data_r <= mem[rd_addr];
  end

  // page dirty tables
  logic [COL_W-1:0] low_r  [PAGE_COUNT];
  logic [COL_W-1:0] high_r [PAGE_COUNT];
  logic             flag_r [PAGE_COUNT];
  logic [COL_W-1:0] tab_low, tab_high;
  logic             tab_flag;

  assign tab_page = cmd.wr_px ? px_page : page_r[PAGE_W-1:0];
  assign tab_low  = low_r[tab_page];
  assign tab_high = high_r[tab_page];
  assign tab_flag = flag_r[tab_page];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PAGE_COUNT; p++) begin
        low_r[p]  <= COL_W'(SCREEN_WIDTH - 1);
        high_r[p] <= '0;
        flag_r[p] <= 1'b0;
      end
    end else if (cmd.tab_fill) begin
      for (int p = 0; p < PAGE_COUNT; p++) begin
        low_r[p]  <= '0;
        high_r[p] <= COL_W'(SCREEN_WIDTH - 1);
        flag_r[p] <= 1'b1;
      end
    end else if (cmd.wr_px) begin
      flag_r[tab_page] <= 1'b1;
      if (tab_low > px_col)  low_r[tab_page]  <= px_col;
      if (tab_high < px_col) high_r[tab_page] <= px_col;
    end else if (cmd.tab_flush) begin
      // an unwritten page keeps its range
      if (tab_flag) begin
        low_r[tab_page]  <= COL_W'(SCREEN_WIDTH - 1);
        high_r[tab_page] <= '0;
      end
      flag_r[tab_page] <= 1'b0;
    end
  end

  // result registers
  logic                 out_valid_r, status_r, written_r;
  logic [BYTE_W-1:0]    byte_r;
  logic [DIRTY_W-1:0]   dmin_r, dmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status_r  <= 1'b0;
      byte_r    <= '0;
      written_r <= 1'b0;
      dmin_r    <= '0;
      dmax_r    <= '0;
      case (cmd.res_sel) inside
        RES_BAD: status_r <= 1'b1;
        RES_BYTE, RES_PAGE: begin
          if (cmd.res_sel == RES_BYTE) byte_r <= rd_data_r;
          written_r <= tab_flag;
          dmin_r    <= DIRTY_W'(tab_low);
          dmax_r    <= DIRTY_W'(tab_high);
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_read_byte    = byte_r;
  assign out_page_written = written_r;
  assign out_dirty_min    = dmin_r;
  assign out_dirty_max    = dmax_r;

  `ASSERT_CLK_ALWAYS(a_wr_addr_known, clk, mem_we |-> !$isunknown(wr_addr), "bad write address")
  `ASSERT_CLK(a_one_port_user, clk, rst_n, cmd.sweep_wr |-> !(cmd.wr_px || mem_re), "port clash")
  `ASSERT_CLK(a_result_one_beat, clk, rst_n, out_valid_r |=> !out_valid_r, "result beat held")

endmodule

### tb/sv/tb_line_raster_page_framebuffer_core.sv
// Testbench for line_raster_page_framebuffer_core: directed table, then random commands,
// each result checked against a typed reply or an in-bench model of the page store and dirty tables.
// Depends on lrpf_pkg and the RTL of the frame buffer core.
`timescale 1ns / 100ps
module tb_line_raster_page_framebuffer_core;
  import lrpf_pkg::*;

  localparam int RANDOM_ITEMS   = 1800;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int RESET_CYCLES   = 11;

  typedef struct {
    op_t      op;
    bit [7:0] xs;
    bit [7:0] ys;
    bit [7:0] xe;
    bit [7:0] ye;
    bit       color;
    bit [7:0] page;
    bit [7:0] col;
  } command_t;

  typedef struct {
    bit       status;
    bit [7:0] read_byte;
    bit       page_written;
    bit [6:0] dirty_min;
    bit [6:0] dirty_max;
  } reply_t;

  typedef struct {
    command_t cmd;
    bit       typed;
    reply_t   want;
  } table_row_t;

  localparam reply_t ZERO_REPLY = '{1'b0, 8'h00, 1'b0, 7'd0, 7'd0};
  localparam reply_t BAD_REPLY  = '{1'b1, 8'h00, 1'b0, 7'd0, 7'd0};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_op = OP_DRAW;
  logic [7:0] in_x_start = '0;
  logic [7:0] in_y_start = '0;
  logic [7:0] in_x_end = '0;
  logic [7:0] in_y_end = '0;
  logic       in_color = 1'b0;
  logic [7:0] in_page_index = '0;
  logic [7:0] in_column_index = '0;
  logic       out_valid;
  logic       out_status;
  logic [7:0] out_read_byte;
  logic       out_page_written;
  logic [6:0] out_dirty_min;
  logic [6:0] out_dirty_max;

  // model state of the page store
  bit [7:0] pixel_bytes [STORE_BYTES];
  bit [6:0] page_low [PAGE_COUNT];
  bit [6:0] page_high [PAGE_COUNT];
  bit       page_flag [PAGE_COUNT];

  reply_t     pending_replies [$];
  table_row_t directed_rows [$];
  int         mismatches = 0;
  int         quiet_cycles = 0;
  bit [7:0]   last_x = 0;
  bit [7:0]   last_y = 0;

  line_raster_page_framebuffer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_x_start       (in_x_start),
    .in_y_start       (in_y_start),
    .in_x_end         (in_x_end),
    .in_y_end         (in_y_end),
    .in_color         (in_color),
    .in_page_index    (in_page_index),
    .in_column_index  (in_column_index),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_read_byte    (out_read_byte),
    .out_page_written (out_page_written),
    .out_dirty_min    (out_dirty_min),
    .out_dirty_max    (out_dirty_max)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one command to the model store and return the reply it owes.
  function automatic reply_t apply_command(command_t c);
    reply_t r;
    int x0, y0, x1, y1, dx, dy, err, sx, sy, e2, pg, idx;
    r = ZERO_REPLY;
    case (c.op)
      OP_DRAW: begin
        if (c.xs >= SCREEN_WIDTH || c.xe >= SCREEN_WIDTH ||
            c.ys >= SCREEN_HEIGHT || c.ye >= SCREEN_HEIGHT) begin
          r.status = 1'b1;
        end else begin
          x0 = c.xs; y0 = c.ys; x1 = c.xe; y1 = c.ye;
          dx = (x1 > x0) ? x1 - x0 : x0 - x1;
          dy = -((y1 > y0) ? y1 - y0 : y0 - y1);
          err = dx + dy;
          sx = (x0 < x1) ? 1 : -1;
          sy = (y0 < y1) ? 1 : -1;
          while (1) begin
            pg = y0 >> 3;
            idx = pg * SCREEN_WIDTH + x0;
            pixel_bytes[idx][y0 & 7] = c.color;
            page_flag[pg] = 1'b1;
            if (int'(page_low[pg]) > x0) page_low[pg] = 7'(x0);
            if (int'(page_high[pg]) < x0) page_high[pg] = 7'(x0);
            if (x0 == x1 && y0 == y1) break;
            e2 = err * 2;
            if (e2 >= dy) begin
              err += dy;
              x0 += sx;
            end
            if (e2 <= dx) begin
              err += dx;
              y0 += sy;
            end
          end
        end
      end
      OP_READ: begin
        if (c.page >= PAGE_COUNT || c.col >= SCREEN_WIDTH) begin
          r.status = 1'b1;
        end else begin
          r.read_byte    = pixel_bytes[c.page * SCREEN_WIDTH + c.col];
          r.page_written = page_flag[c.page];
          r.dirty_min    = page_low[c.page];
          r.dirty_max    = page_high[c.page];
        end
      end
      OP_FLUSH: begin
        if (c.page >= PAGE_COUNT) begin
          r.status = 1'b1;
        end else begin
          r.page_written = page_flag[c.page];
          r.dirty_min    = page_low[c.page];
          r.dirty_max    = page_high[c.page];
          // an unwritten page keeps its range as it is
          if (page_flag[c.page]) begin
            page_low[c.page]  = 7'(SCREEN_WIDTH - 1);
            page_high[c.page] = 7'd0;
          end
          page_flag[c.page] = 1'b0;
        end
      end
      default: begin
        for (int i = 0; i < STORE_BYTES; i++) pixel_bytes[i] = 8'h00;
        for (int p = 0; p < PAGE_COUNT; p++) begin
          page_low[p]  = 7'd0;
          page_high[p] = 7'(SCREEN_WIDTH - 1);
          page_flag[p] = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic bit [7:0] nudge(bit [7:0] base, int span);
    int v;
    v = int'($urandom_range(0, 2 * span));
    v = v + int'(base) - span;
    if (v < 0) v = 0;
    if (v > SCREEN_WIDTH - 1) v = SCREEN_WIDTH - 1;
    return 8'(v);
  endfunction

  function automatic command_t random_command();
    command_t c;
    int r, pick;
    // fields an op ignores stay fully random
    c.xs = 8'($urandom); c.ys = 8'($urandom);
    c.xe = 8'($urandom); c.ye = 8'($urandom);
    c.page = 8'($urandom); c.col = 8'($urandom);
    c.color = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 56) begin
      c.op = OP_DRAW;
      pick = $urandom_range(0, 99);
      c.xs = 8'($urandom_range(0, SCREEN_WIDTH - 1));
      c.ys = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
      if (pick < 68) begin
        c.xe = nudge(c.xs, 8);
        c.ye = nudge(c.ys, 8);
      end else if (pick < 80) begin
        c.xe = c.xs;
        c.ye = c.ys;
      end else begin
        c.xe = 8'($urandom_range(0, SCREEN_WIDTH - 1));
        c.ye = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
      end
      if (pick >= 95) begin
        case ($urandom_range(0, 3))
          0: c.xs = 8'($urandom_range(SCREEN_WIDTH, 255));
          1: c.ys = 8'($urandom_range(SCREEN_HEIGHT, 255));
          2: c.xe = 8'($urandom_range(SCREEN_WIDTH, 255));
          default: c.ye = 8'($urandom_range(SCREEN_HEIGHT, 255));
        endcase
      end else begin
        last_x = c.xe;
        last_y = c.ye;
      end
    end else if (r < 84) begin
      c.op = OP_READ;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // aim at the end of the last line drawn
        c.page = last_y >> 3;
        c.col  = last_x;
      end else if (pick < 95) begin
        c.page = 8'($urandom_range(0, PAGE_COUNT - 1));
        c.col  = 8'($urandom_range(0, SCREEN_WIDTH - 1));
      end else if ($urandom_range(0, 1)) begin
        c.page = 8'($urandom_range(PAGE_COUNT, 255));
      end else begin
        c.page = 8'($urandom_range(0, PAGE_COUNT - 1));
        c.col  = 8'($urandom_range(SCREEN_WIDTH, 255));
      end
    end else if (r < 99) begin
      c.op = OP_FLUSH;
      if ($urandom_range(0, 99) < 95) c.page = 8'($urandom_range(0, PAGE_COUNT - 1));
      else c.page = 8'($urandom_range(PAGE_COUNT, 255));
    end else begin
      c.op = OP_CLEAR;
    end
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // Present one command beat and hold it until taken.
  task automatic issue(input command_t c, input int gap, input bit typed, input reply_t typed_reply);
    reply_t owed;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_op           <= c.op;
    in_x_start      <= c.xs;
    in_y_start      <= c.ys;
    in_x_end        <= c.xe;
    in_y_end        <= c.ye;
    in_color        <= c.color;
    in_page_index   <= c.page;
    in_column_index <= c.col;
    start           <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    owed = apply_command(c);
    pending_replies.push_back(typed ? typed_reply : owed);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $error("result beat with no command pending");
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_read_byte !== want.read_byte) begin
          $error("read_byte: expected %02h, got %02h", want.read_byte, out_read_byte);
          mismatches++;
        end
        if (out_page_written !== want.page_written) begin
          $error("page_written: expected %0d, got %0d", want.page_written, out_page_written);
          mismatches++;
        end
        if (out_dirty_min !== want.dirty_min) begin
          $error("dirty_min: expected %0d, got %0d", want.dirty_min, out_dirty_min);
          mismatches++;
        end
        if (out_dirty_max !== want.dirty_max) begin
          $error("dirty_max: expected %0d, got %0d", want.dirty_max, out_dirty_max);
          mismatches++;
        end
      end
    end
  end

  // End the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int burst_left;
    int gap;
    for (int i = 0; i < STORE_BYTES; i++) pixel_bytes[i] = 8'h00;
    for (int p = 0; p < PAGE_COUNT; p++) begin
      page_low[p]  = 7'(SCREEN_WIDTH - 1);
      page_high[p] = 7'd0;
      page_flag[p] = 1'b0;
    end

    directed_rows.push_back('{'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0},
                              1'b1, '{1'b0, 8'h00, 1'b0, 7'd127, 7'd0}});
    directed_rows.push_back('{'{OP_FLUSH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd15, 8'hFF},
                              1'b1, '{1'b0, 8'h00, 1'b0, 7'd127, 7'd0}});
    directed_rows.push_back('{'{OP_DRAW, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'hFF, 8'hFF},
                              1'b1, ZERO_REPLY});
    directed_rows.push_back('{'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0},
                              1'b1, '{1'b0, 8'h01, 1'b1, 7'd0, 7'd0}});
    directed_rows.push_back('{'{OP_DRAW, 8'd127, 8'd127, 8'd127, 8'd127, 1'b1, 8'd0, 8'd0},
                              1'b1, ZERO_REPLY});
    directed_rows.push_back('{'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd15, 8'd127},
                              1'b1, '{1'b0, 8'h80, 1'b1, 7'd127, 7'd127}});
    directed_rows.push_back('{'{OP_DRAW, 8'd0, 8'd0, 8'd127, 8'd127, 1'b1, 8'd0, 8'd0},
                              1'b0, ZERO_REPLY});
    directed_rows.push_back('{'{OP_DRAW, 8'd127, 8'd0, 8'd0, 8'd127, 1'b1, 8'd0, 8'd0},
                              1'b0, ZERO_REPLY});
    directed_rows.push_back('{'{OP_DRAW, 8'd5, 8'd0, 8'd9, 8'd127, 1'b0, 8'd0, 8'd0},
                              1'b0, ZERO_REPLY});
    directed_rows.push_back('{'{OP_DRAW, 8'd0, 8'd64, 8'd127, 8'd64, 1'b1, 8'd0, 8'd0},
                              1'b0, ZERO_REPLY});
    directed_rows.push_back('{'{OP_DRAW, 8'd100, 8'd70, 8'd3, 8'd10, 1'b1, 8'd0, 8'd0},
                              1'b0, ZERO_REPLY});
    directed_rows.push_back('{'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd8, 8'd64},
                              1'b0, ZERO_REPLY});
    directed_rows.push_back('{'{OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd8, 8'd0},
                              1'b0, ZERO_REPLY});
    directed_rows.push_back('{'{OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd8, 8'd0},
                              1'b0, ZERO_REPLY});
    directed_rows.push_back('{'{OP_DRAW, 8'd128, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0},
                              1'b1, BAD_REPLY});
    directed_rows.push_back('{'{OP_DRAW, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 8'd0, 8'd0},
                              1'b1, BAD_REPLY});
    directed_rows.push_back('{'{OP_DRAW, 8'd0, 8'd255, 8'd200, 8'd0, 1'b0, 8'd0, 8'd0},
                              1'b1, BAD_REPLY});
    directed_rows.push_back('{'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd16, 8'd0},
                              1'b1, BAD_REPLY});
    directed_rows.push_back('{'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd128},
                              1'b1, BAD_REPLY});
    directed_rows.push_back('{'{OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd255, 8'd0},
                              1'b1, BAD_REPLY});
    directed_rows.push_back('{'{OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF},
                              1'b1, ZERO_REPLY});
    directed_rows.push_back('{'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd3, 8'd5},
                              1'b1, '{1'b0, 8'h00, 1'b1, 7'd0, 7'd127}});
    directed_rows.push_back('{'{OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd3, 8'd0},
                              1'b1, '{1'b0, 8'h00, 1'b1, 7'd0, 7'd127}});
    directed_rows.push_back('{'{OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd3, 8'd0},
                              1'b1, '{1'b0, 8'h00, 1'b0, 7'd127, 7'd0}});
    directed_rows.push_back('{'{OP_DRAW, 8'd3, 8'd3, 8'd3, 8'd3, 1'b1, 8'd0, 8'd0},
                              1'b0, ZERO_REPLY});
    directed_rows.push_back('{'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd3},
                              1'b1, '{1'b0, 8'h08, 1'b1, 7'd0, 7'd127}});

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      issue(directed_rows[i].cmd, pick_gap(), directed_rows[i].typed, directed_rows[i].want);

    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 400 == 200) hold_until_drained();
      // run back-to-back beats now and then
      if (n % 150 == 0) burst_left = 30;
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = pick_gap();
      end
      issue(random_command(), gap, 1'b0, ZERO_REPLY);
    end
    start <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/lrpf_pkg.sv
hw/rtl/lrpf_ctrl.sv
hw/rtl/lrpf_dp.sv
hw/rtl/line_raster_page_framebuffer_core.sv
tb/sv/tb_line_raster_page_framebuffer_core.sv
